FILE: hdl/rcpf_pkg.sv
// ----------------------------------------------------------------------------
// rcpf_pkg
// Shared types, register codes, reset values and channel tables for the RC
// pulse capture and failsafe block.
// ----------------------------------------------------------------------------
package rcpf_pkg;

  // Number of physical receiver pins carried by an input transaction
  localparam int PIN_COUNT    = 5;
  localparam int CHANNELS_DEF = 5;

  localparam int W_TIMER = 16;
  localparam int W_WIDTH = 13;
  localparam int W_IDLE  = 3;

  // Configuration register indexes
  localparam int W_CFG_INDEX = 3;
  localparam int W_CFG_DATA  = 16;
  localparam logic [W_CFG_INDEX-1:0] CFG_FRAME_PERIOD   = 3'd0;
  localparam logic [W_CFG_INDEX-1:0] CFG_PULSE_LIMIT    = 3'd1;
  localparam logic [W_CFG_INDEX-1:0] CFG_SWITCH_HIGH    = 3'd2;
  localparam logic [W_CFG_INDEX-1:0] CFG_SWITCH_LOW     = 3'd3;
  localparam logic [W_CFG_INDEX-1:0] CFG_SWITCH_FLOOR   = 3'd4;
  localparam logic [W_CFG_INDEX-1:0] CFG_WATCHDOG_LIMIT = 3'd5;

  // Configuration reset values
  localparam logic [W_TIMER-1:0] FRAME_PERIOD_RST   = 16'd39236;
  localparam logic [W_WIDTH-1:0] PULSE_LIMIT_RST    = 13'd4500;
  localparam logic [W_WIDTH-1:0] SWITCH_HIGH_RST    = 13'd3300;
  localparam logic [W_WIDTH-1:0] SWITCH_LOW_RST     = 13'd2500;
  localparam logic [W_WIDTH-1:0] SWITCH_FLOOR_RST   = 13'd1000;
  localparam logic [W_IDLE-1:0]  WATCHDOG_LIMIT_RST = 3'd3;

  // Saturation value of the quiet tick counter
  localparam logic [W_IDLE-1:0] IDLE_MAX = 3'd7;

  // Failsafe widths
  localparam logic [W_WIDTH-1:0] FAILSAFE_WIDTH      = 13'd3000;
  localparam logic [W_WIDTH-1:0] FAILSAFE_WIDTH_CH1  = 13'd1000;

  // Dead-band windows, bounds inclusive
  localparam logic [W_WIDTH-1:0] DB_CH0_LO = 13'd2890;
  localparam logic [W_WIDTH-1:0] DB_CH0_HI = 13'd2930;
  localparam logic [W_WIDTH-1:0] DB_CH2_LO = 13'd2600;
  localparam logic [W_WIDTH-1:0] DB_CH2_HI = 13'd2700;
  localparam logic [W_WIDTH-1:0] DB_CH3_LO = 13'd2860;
  localparam logic [W_WIDTH-1:0] DB_CH3_HI = 13'd2960;

  // Input command codes
  localparam logic CMD_PIN_CHANGE = 1'b0;
  localparam logic CMD_FRAME_TICK = 1'b1;

  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_EMERG  = 2'd2
  } mode_t;

  typedef struct packed {
    logic                 command;
    logic [PIN_COUNT-1:0] pin_levels;
    logic [W_TIMER-1:0]   timer_now;
  } item_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [W_WIDTH-1:0] width_ch0;
    logic [W_WIDTH-1:0] width_ch1;
    logic [W_WIDTH-1:0] width_ch2;
    logic [W_WIDTH-1:0] width_ch3;
    logic [W_WIDTH-1:0] width_ch4;
    logic [W_WIDTH-1:0] switch_width;
  } result_t;

  typedef struct packed {
    logic [W_TIMER-1:0] frame_period;
    logic [W_WIDTH-1:0] pulse_limit;
    logic [W_WIDTH-1:0] switch_high;
    logic [W_WIDTH-1:0] switch_low;
    logic [W_WIDTH-1:0] switch_floor;
    logic [W_IDLE-1:0]  watchdog_limit;
  } cfg_t;

  // Event seen by every lane
  typedef struct packed {
    logic               is_pin;
    logic [W_TIMER-1:0] now;
  } evt_t;

  // Measurement reported by a lane
  typedef struct packed {
    logic               valid;
    logic [W_WIDTH-1:0] width;
  } meas_t;

  // Mode controls handed to the lanes
  typedef struct packed {
    logic manual;
    logic load_failsafe;
  } ctl_t;

  function automatic logic [W_WIDTH-1:0] reset_width(input int idx);
    logic [W_WIDTH-1:0] w;
    case (idx)
      0:       w = 13'd2950;
      1:       w = 13'd2000;
      2:       w = 13'd2700;
      default: w = 13'd3000;
    endcase
    return w;
  endfunction

  function automatic logic [W_WIDTH-1:0] failsafe_width(input int idx);
    return (idx == 1) ? FAILSAFE_WIDTH_CH1 : FAILSAFE_WIDTH;
  endfunction

  // True when both widths sit inside the channel's dead band
  function automatic logic in_dead_band(input int idx, input logic [W_WIDTH-1:0] a,
                                        input logic [W_WIDTH-1:0] b);
    logic [W_WIDTH-1:0] lo;
    logic [W_WIDTH-1:0] hi;
    logic               en;
    en = 1'b1;
    lo = '0;
    hi = '0;
    case (idx)
      0: begin
        lo = DB_CH0_LO;
        hi = DB_CH0_HI;
      end
      2: begin
        lo = DB_CH2_LO;
        hi = DB_CH2_HI;
      end
      3: begin
        lo = DB_CH3_LO;
        hi = DB_CH3_HI;
      end
      default: en = 1'b0;
    endcase
    return en && (a >= lo) && (a <= hi) && (b >= lo) && (b <= hi);
  endfunction

endpackage

FILE: hdl/rcpf_lane.sv
// ----------------------------------------------------------------------------
// rcpf_lane
// One receiver channel: edge detect, start time capture, width measurement
// with frame wrap, validity check and averaging into the desired width.
// ----------------------------------------------------------------------------
module rcpf_lane #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  rcpf_pkg::evt_t                     evt,
  input  logic                               level,
  input  rcpf_pkg::cfg_t                     cfg,
  input  rcpf_pkg::ctl_t                     ctl,
  output rcpf_pkg::meas_t                    meas,
  output logic [rcpf_pkg::W_WIDTH-1:0]       width_next
);

  localparam logic HIST_INIT = (IDX < rcpf_pkg::PIN_COUNT) ? 1'b1 : 1'b0;

  logic                          hist;
  logic [rcpf_pkg::W_TIMER-1:0]  start;
  logic [rcpf_pkg::W_WIDTH-1:0]  desired;

  logic                          changed;
  logic                          rise;
  logic                          fall;
  logic [rcpf_pkg::W_TIMER+1:0]  span;
  logic                          in_range;
  logic [rcpf_pkg::W_WIDTH:0]    sum;
  logic [rcpf_pkg::W_WIDTH-1:0]  avg;
  logic                          dead;

  // Detect the edge on this pin
  assign changed = evt.is_pin && (level != hist);
  assign rise    = changed && level;
  assign fall    = changed && !level;

  // Measure the width, unwrapping across the frame; a negative span is invalid
  always_comb begin
    if (evt.now >= start) begin
      span = {2'b00, evt.now} - {2'b00, start};
    end else begin
      span = {2'b00, evt.now} + {2'b00, cfg.frame_period} - {2'b00, start};
    end
  end

  assign in_range = !span[rcpf_pkg::W_TIMER+1]
                 && (span[rcpf_pkg::W_TIMER:0] != '0)
                 && (span[rcpf_pkg::W_TIMER:0] < {4'b0000, cfg.pulse_limit});

  assign meas.valid = fall && in_range;
  assign meas.width = span[rcpf_pkg::W_WIDTH-1:0];

  // Average into the desired width in manual mode outside the dead band
  assign sum  = {1'b0, meas.width} + {1'b0, desired};
  assign avg  = sum[rcpf_pkg::W_WIDTH:1];
  assign dead = rcpf_pkg::in_dead_band(IDX, desired, meas.width);

  always_comb begin
    if (ctl.load_failsafe) begin
      width_next = rcpf_pkg::failsafe_width(IDX);
    end else if (meas.valid && ctl.manual && !dead) begin
      width_next = avg;
    end else begin
      width_next = desired;
    end
  end

  // Hold channel state, advance on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      hist    <= HIST_INIT;
      start   <= '0;
      desired <= rcpf_pkg::reset_width(IDX);
    end else if (fire) begin
      if (evt.is_pin) begin
        hist <= level;
      end
      if (rise) begin
        start <= evt.now;
      end
      desired <= width_next;
    end
  end

endmodule

FILE: hdl/rcpf_ctrl.sv
// ----------------------------------------------------------------------------
// rcpf_ctrl
// Mode controller: quiet tick watchdog, switch channel value and the
// manual / auto / emergency transitions.
// ----------------------------------------------------------------------------
module rcpf_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic                          is_tick,
  input  rcpf_pkg::meas_t               switch_meas,
  input  rcpf_pkg::cfg_t                cfg,
  output rcpf_pkg::ctl_t                ctl,
  output rcpf_pkg::mode_t               mode_next,
  output logic [rcpf_pkg::W_WIDTH-1:0]  switch_next
);

  rcpf_pkg::mode_t               mode;
  logic [rcpf_pkg::W_WIDTH-1:0]  switch_value;
  logic [rcpf_pkg::W_IDLE-1:0]   idle_ticks;

  logic                          trip;
  rcpf_pkg::mode_t               mode_mid;
  logic [rcpf_pkg::W_IDLE-1:0]   idle_next;

  // Watchdog trip on a frame tick outside emergency
  assign trip = is_tick && (mode != rcpf_pkg::MODE_EMERG) && (idle_ticks > cfg.watchdog_limit);

  assign mode_mid = trip ? rcpf_pkg::MODE_EMERG : mode;

  always_comb begin
    if (trip) begin
      switch_next = '0;
    end else if (!is_tick && switch_meas.valid) begin
      switch_next = switch_meas.width;
    end else begin
      switch_next = switch_value;
    end
  end

  // Clear on pin activity, count quiet ticks with saturation, hold in emergency
  always_comb begin
    if (!is_tick) begin
      idle_next = '0;
    end else if (mode == rcpf_pkg::MODE_EMERG || idle_ticks == rcpf_pkg::IDLE_MAX) begin
      idle_next = idle_ticks;
    end else begin
      idle_next = idle_ticks + 3'd1;
    end
  end

  // Mode transitions on the switch value
  always_comb begin
    mode_next = mode_mid;
    case (mode_mid)
      rcpf_pkg::MODE_MANUAL: begin
        if (switch_next > cfg.switch_high) mode_next = rcpf_pkg::MODE_AUTO;
      end
      rcpf_pkg::MODE_AUTO: begin
        if (switch_next < cfg.switch_low) mode_next = rcpf_pkg::MODE_MANUAL;
      end
      rcpf_pkg::MODE_EMERG: begin
        if (switch_next > cfg.switch_high) begin
          mode_next = rcpf_pkg::MODE_AUTO;
        end else if (switch_next < cfg.switch_low && switch_next > cfg.switch_floor) begin
          mode_next = rcpf_pkg::MODE_MANUAL;
        end
      end
      default: mode_next = rcpf_pkg::MODE_EMERG;
    endcase
  end

  assign ctl.manual        = (mode == rcpf_pkg::MODE_MANUAL);
  assign ctl.load_failsafe = (mode_mid == rcpf_pkg::MODE_EMERG);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= rcpf_pkg::MODE_MANUAL;
      switch_value <= '0;
      idle_ticks   <= '0;
    end else if (fire) begin
      mode         <= mode_next;
      switch_value <= switch_next;
      idle_ticks   <= idle_next;
    end
  end

endmodule

FILE: hdl/rc_pulse_capture_failsafe.sv
// ----------------------------------------------------------------------------
// rc_pulse_capture_failsafe
// RC receiver pulse width capture with manual / auto / emergency mode and a
// frame tick watchdog that loads failsafe widths.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  item      in         item_valid / item_stall    rcpf_pkg::item_t
//  result    out        result_valid / result_stall rcpf_pkg::result_t
//  cfg       in         cfg_wen                    cfg_index, cfg_data
//
//  One transaction per cycle sustained while the result is not stalled; a
//  result passes the input register, then the result register. All channel
//  lanes and the mode controller update as the input register moves on.
//  Synchronous reset clears the valid flags and controller state and loads
//  the configuration and channel reset values; payloads are not reset.
//  A stalled result holds the input register; item_stall rises if it is full.
// ----------------------------------------------------------------------------
module rc_pulse_capture_failsafe #(
  parameter int CHANNELS = rcpf_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  rcpf_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output rcpf_pkg::result_t                 result,
  input  logic                              cfg_wen,
  input  logic [rcpf_pkg::W_CFG_INDEX-1:0]  cfg_index,
  input  logic [rcpf_pkg::W_CFG_DATA-1:0]   cfg_data
);

  rcpf_pkg::cfg_t                cfg;
  logic                          s1_valid;
  rcpf_pkg::item_t               s1_item;
  logic                          advance;
  logic                          fire;
  rcpf_pkg::evt_t                evt;
  rcpf_pkg::ctl_t                ctl;
  rcpf_pkg::mode_t               mode_next;
  logic [rcpf_pkg::W_WIDTH-1:0]  switch_next;
  logic [CHANNELS-1:0]           level;
  rcpf_pkg::meas_t               meas [CHANNELS];
  logic [rcpf_pkg::W_WIDTH-1:0]  width_next [CHANNELS];
  logic [rcpf_pkg::W_WIDTH-1:0]  width_out [rcpf_pkg::PIN_COUNT];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_period   <= rcpf_pkg::FRAME_PERIOD_RST;
      cfg.pulse_limit    <= rcpf_pkg::PULSE_LIMIT_RST;
      cfg.switch_high    <= rcpf_pkg::SWITCH_HIGH_RST;
      cfg.switch_low     <= rcpf_pkg::SWITCH_LOW_RST;
      cfg.switch_floor   <= rcpf_pkg::SWITCH_FLOOR_RST;
      cfg.watchdog_limit <= rcpf_pkg::WATCHDOG_LIMIT_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        rcpf_pkg::CFG_FRAME_PERIOD:   cfg.frame_period   <= cfg_data;
        rcpf_pkg::CFG_PULSE_LIMIT:    cfg.pulse_limit    <= cfg_data[rcpf_pkg::W_WIDTH-1:0];
        rcpf_pkg::CFG_SWITCH_HIGH:    cfg.switch_high    <= cfg_data[rcpf_pkg::W_WIDTH-1:0];
        rcpf_pkg::CFG_SWITCH_LOW:     cfg.switch_low     <= cfg_data[rcpf_pkg::W_WIDTH-1:0];
        rcpf_pkg::CFG_SWITCH_FLOOR:   cfg.switch_floor   <= cfg_data[rcpf_pkg::W_WIDTH-1:0];
        rcpf_pkg::CFG_WATCHDOG_LIMIT: cfg.watchdog_limit <= cfg_data[rcpf_pkg::W_IDLE-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the input register moves on when the result slot frees
  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign fire       = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  assign evt.is_pin = (s1_item.command == rcpf_pkg::CMD_PIN_CHANGE);
  assign evt.now    = s1_item.timer_now;

  // Channel lanes; pins beyond the receiver read low
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    if (i < rcpf_pkg::PIN_COUNT) begin : g_pin
      assign level[i] = s1_item.pin_levels[i];
    end else begin : g_nopin
      assign level[i] = 1'b0;
    end

    rcpf_lane #(
      .IDX (i)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .fire       (fire),
      .evt        (evt),
      .level      (level[i]),
      .cfg        (cfg),
      .ctl        (ctl),
      .meas       (meas[i]),
      .width_next (width_next[i])
    );
  end

  rcpf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .is_tick     (s1_item.command == rcpf_pkg::CMD_FRAME_TICK),
    .switch_meas (meas[CHANNELS-1]),
    .cfg         (cfg),
    .ctl         (ctl),
    .mode_next   (mode_next),
    .switch_next (switch_next)
  );

  // Pad the reported widths; absent channels read zero
  for (genvar j = 0; j < rcpf_pkg::PIN_COUNT; j++) begin : g_out
    if (j < CHANNELS) begin : g_used
      assign width_out[j] = width_next[j];
    end else begin : g_unused
      assign width_out[j] = '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.mode         <= mode_next;
      result.width_ch0    <= width_out[0];
      result.width_ch1    <= width_out[1];
      result.width_ch2    <= width_out[2];
      result.width_ch3    <= width_out[3];
      result.width_ch4    <= width_out[4];
      result.switch_width <= switch_next;
    end
  end

  // Input only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("item stalled without a stalled result");

  // A processed transaction always produces a result next cycle
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("processed transaction lost its result");

  // Emergency results carry the failsafe width on channel 0
  a_emerg_failsafe: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.mode == rcpf_pkg::MODE_EMERG)
      |-> (result.width_ch0 == rcpf_pkg::FAILSAFE_WIDTH))
    else $error("emergency result without failsafe width");

endmodule
